@@ hw/rtl/clar_pkg.sv @@
// ----------------------------------------------------------------------------
// clar_pkg
// Shared sizes and codes for the contiguous list with append and remove.
// ----------------------------------------------------------------------------
package clar_pkg;

	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int IDX_W    = 6;
	localparam int CNT_W    = 7;
	localparam int STAT_W   = 2;

	// operation codes on the func field
	localparam logic FUNC_APPEND = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	// result status codes
	localparam logic [STAT_W-1:0] STATUS_DONE      = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_NOT_FOUND = 2'd2;

endpackage

@@ hw/rtl/contiguous_list_append_remove.sv @@
// ----------------------------------------------------------------------------
// contiguous_list_append_remove
// Ordered list of 32-bit values packed from position 0, held in one RAM.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_ready) carries one word: func and item_value.
// func 0 appends item_value after the last entry; func 1 removes the first
// entry equal to item_value and moves every later entry down by one place.
// Output channel (out_valid / out_ready) returns one word per input word:
// status, position and entry_count after the operation.
// One word is in work at a time. An append passes through ST_APPEND to the
// result state. A remove streams the list through the single RAM read port,
// one entry per cycle, first comparing and then copying each later entry one
// place down. A remove on an empty list goes straight to the result state.
// in_ready returns with out_valid.
// The result sits in an output register, so a stalled receiver holds
// out_valid and the payload; the next input word is accepted and worked on
// meanwhile, and its result waits until the register frees up.
// Reset (arst_n low) empties the list at once; no clearing pass runs.
// ----------------------------------------------------------------------------
module contiguous_list_append_remove (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic signed [clar_pkg::DATA_W-1:0] item_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [clar_pkg::STAT_W-1:0]   status,
	output logic [clar_pkg::IDX_W-1:0]    position,
	output logic [clar_pkg::CNT_W-1:0]    entry_count
);
	import clar_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APPEND,
		ST_SCAN,
		ST_SHIFT,
		ST_RESP
	} state_t;

	state_t              state_q;
	logic                func_q;
	logic [DATA_W-1:0]   val_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    idx_q;
	logic [STAT_W-1:0]   res_stat_q;
	logic [IDX_W-1:0]    res_pos_q;
	logic                out_valid_q;
	logic [STAT_W-1:0]   status_q;
	logic [IDX_W-1:0]    position_q;
	logic [CNT_W-1:0]    entry_count_q;

	// read pipe
	logic                rd_vld_s1;
	logic [IDX_W-1:0]    tag_s1;
	logic [DATA_W-1:0]   rd_data_s1;

	logic [DATA_W-1:0]   mem [CAPACITY];

	logic                issue;
	logic                hit;
	logic                last;
	logic                full;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	logic [DATA_W-1:0]   wr_data;

	// read one entry a cycle while scanning or shifting, up to the fill count
	assign issue = ((state_q == ST_SCAN) || (state_q == ST_SHIFT)) && (idx_q < cnt_q);
	assign hit   = rd_vld_s1 && (state_q == ST_SCAN) && (rd_data_s1 == val_q);
	assign last  = rd_vld_s1 && ({1'b0, tag_s1} == (cnt_q - 1'b1));
	assign full  = (cnt_q == CNT_W'(CAPACITY));

	// write the appended value, or move a read entry one place down
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = tag_s1 - 1'b1;
		wr_data = rd_data_s1;
		if (state_q == ST_APPEND) begin
			wr_en   = !full;
			wr_addr = cnt_q[IDX_W-1:0];
			wr_data = val_q;
		end else if (state_q == ST_SHIFT) begin
			wr_en = rd_vld_s1;
		end
	end

	// list storage, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (issue) begin
			rd_data_s1 <= mem[idx_q[IDX_W-1:0]];
		end
	end

	// control, read tags and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			func_q        <= FUNC_APPEND;
			val_q         <= '0;
			cnt_q         <= '0;
			idx_q         <= '0;
			res_stat_q    <= STATUS_DONE;
			res_pos_q     <= '0;
			rd_vld_s1     <= 1'b0;
			tag_s1        <= '0;
			out_valid_q   <= 1'b0;
			status_q      <= STATUS_DONE;
			position_q    <= '0;
			entry_count_q <= '0;
		end else begin
			rd_vld_s1 <= issue;
			tag_s1    <= idx_q[IDX_W-1:0];
			if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			// drop the taken word unless a new result replaces it
			if (out_valid_q && out_ready && (state_q != ST_RESP)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						func_q <= func;
						val_q  <= item_value;
						idx_q  <= '0;
						if (func == FUNC_APPEND) begin
							state_q <= ST_APPEND;
						end else if (cnt_q == '0) begin
							res_stat_q <= STATUS_NOT_FOUND;
							res_pos_q  <= '0;
							state_q    <= ST_RESP;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_APPEND: begin
					if (full) begin
						res_stat_q <= STATUS_FULL;
						res_pos_q  <= '0;
					end else begin
						res_stat_q <= STATUS_DONE;
						res_pos_q  <= cnt_q[IDX_W-1:0];
						cnt_q      <= cnt_q + 1'b1;
					end
					state_q <= ST_RESP;
				end
				ST_SCAN: begin
					if (hit) begin
						res_stat_q <= STATUS_DONE;
						res_pos_q  <= tag_s1;
						if (last) begin
							cnt_q   <= cnt_q - 1'b1;
							state_q <= ST_RESP;
						end else begin
							state_q <= ST_SHIFT;
						end
					end else if (last) begin
						res_stat_q <= STATUS_NOT_FOUND;
						res_pos_q  <= '0;
						state_q    <= ST_RESP;
					end
				end
				ST_SHIFT: begin
					// drop the count once the last entry has moved down
					if (last) begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q   <= 1'b1;
						status_q      <= res_stat_q;
						position_q    <= res_pos_q;
						entry_count_q <= cnt_q;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign position    = position_q;
	assign entry_count = entry_count_q;

	// the list never holds more than its capacity
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("fill count above capacity");

	// no read is in flight when a new word can be taken
	a_pipe_drained: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !rd_vld_s1)
		else $error("read still in flight at accept");

	// a shift never writes the entry being read in the same cycle
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && issue) |-> (wr_addr != idx_q[IDX_W-1:0]))
		else $error("write and read address collide");

	// the count moves only at the end of an append or a remove
	a_cnt_change: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |->
		($past(state_q) == ST_APPEND || $past(state_q) == ST_SCAN ||
		 $past(state_q) == ST_SHIFT))
		else $error("fill count changed outside an operation");

	// a finished append leaves a result for the output register
	a_resp_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPEND) |=> (state_q == ST_RESP))
		else $error("append did not complete");

	// entries only move down while a remove is in work
	a_func_remove: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> (func_q == FUNC_REMOVE))
		else $error("shift outside a remove");

endmodule
